### hdl/lats_pkg.sv
`timescale 1ns / 1ps

package lats_pkg;

    // grid store dimensions
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int NR_W   = ROW_W + 1;   // holds a row count up to MAX_ROWS
    localparam int NC_W   = COL_W + 1;   // holds a column count up to MAX_COLS
    localparam int SIZE_W = 7;           // size register width

    localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(64);

    // Life rule
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] SURVIVE_LOW = 4'd2;

    // configuration register indices
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // request codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_STEP  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_USE,
        ST_ROW_START,
        ST_GEN_RD_DN,
        ST_GEN_RD_UP,
        ST_GEN_UP,
        ST_GEN_CELLS,
        ST_GEN_WB,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
    } mem_req_t;

    // zero acts as one, anything above the store size acts as the store size
    function automatic logic [NR_W-1:0] clamp_rows(input logic [SIZE_W-1:0] v);
        logic [NR_W-1:0] res;
        if (v == '0)
            res = NR_W'(1);
        else if (int'(v) > MAX_ROWS)
            res = NR_W'(MAX_ROWS);
        else
            res = NR_W'(v);
        return res;
    endfunction

    function automatic logic [NC_W-1:0] clamp_cols(input logic [SIZE_W-1:0] v);
        logic [NC_W-1:0] res;
        if (v == '0)
            res = NC_W'(1);
        else if (int'(v) > MAX_COLS)
            res = NC_W'(MAX_COLS);
        else
            res = NC_W'(v);
        return res;
    endfunction

endpackage

### hdl/lats_row_mem.sv
`timescale 1ns / 1ps

// One row of cells per word; a row never written reads as all dead.
module lats_row_mem
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lats_pkg::mem_req_t            req,
    input  logic [lats_pkg::MAX_COLS-1:0] wr_data,
    output logic [lats_pkg::MAX_COLS-1:0] rd_data
);

    logic [lats_pkg::MAX_COLS-1:0] mem [lats_pkg::MAX_ROWS];
    logic [lats_pkg::MAX_ROWS-1:0] row_valid_reg;
    logic [lats_pkg::MAX_COLS-1:0] rd_word_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                row_valid_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en)
                rd_valid_reg <= row_valid_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= wr_data;
        if (req.rd_en)
            rd_word_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

### hdl/lats_cell_unit.sv
`timescale 1ns / 1ps

// Next state of one cell from the three old rows around it, with wrap.
module lats_cell_unit
(
    input  logic [lats_pkg::MAX_COLS-1:0] up_row,
    input  logic [lats_pkg::MAX_COLS-1:0] cur_row,
    input  logic [lats_pkg::MAX_COLS-1:0] dn_row,
    input  logic [lats_pkg::COL_W-1:0]    col,
    input  logic [lats_pkg::NC_W-1:0]     nc,
    output logic                          cell_next
);

    logic [lats_pkg::COL_W-1:0] lf;
    logic [lats_pkg::COL_W-1:0] rt;
    logic [3:0]                 n;
    logic                       alive;

    always_comb
    begin
        lf = (col == '0) ? lats_pkg::COL_W'(nc - 1'b1) : col - 1'b1;
        rt = ((lats_pkg::NC_W'(col) + 1'b1) == nc) ? '0 : col + 1'b1;

        n = 4'(up_row[lf]) + 4'(up_row[col]) + 4'(up_row[rt])
          + 4'(cur_row[lf])                  + 4'(cur_row[rt])
          + 4'(dn_row[lf]) + 4'(dn_row[col]) + 4'(dn_row[rt]);

        alive = cur_row[col];
        if (alive)
            cell_next = (n == lats_pkg::SURVIVE_LOW) || (n == lats_pkg::BIRTH_COUNT);
        else
            cell_next = (n == lats_pkg::BIRTH_COUNT);
    end

endmodule

### hdl/life_automaton_torus_step.sv
`timescale 1ns / 1ps

// Channel  Dir  Signals                         Contents
// s        in   s_tvalid s_tready s_tdata s_tuser  request: func, row, column, value
// m        out  m_tvalid m_tready m_tdata          result: cell_value, accepted
// cfg      in   cfg_we cfg_index cfg_data          rows_in_use (0), cols_in_use (1)
//
// Write/read: the request passes ST_ACC_RD and ST_ACC_USE (row read-modify-write) before
//   ST_RESULT loads the result register; an out-of-range address or unknown func goes straight there.
// Generation: one cell per cycle through the single evaluator, plus per-row states for fetches,
//   buffer load and write-back (ST_ROW_START, ST_GEN_RD_DN, ST_GEN_RD_UP, ST_GEN_UP, ST_GEN_WB).
// One request at a time; s_tready is high only while idle. A result waiting in the
//   output register does not block acceptance, only the finish of the next request.
// Reset is asynchronous and leaves every cell dead at once (per-row valid flags).

module life_automaton_torus_step
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [5:0] row, [11:6] column, [12] value
    input  logic [1:0]                  s_tuser,   // [1:0] func

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [0] cell_value, [1] accepted

    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [lats_pkg::SIZE_W-1:0] cfg_data
);

    localparam int MC = lats_pkg::MAX_COLS;

    lats_pkg::state_t state_reg, state_next;

    // configuration
    logic [lats_pkg::SIZE_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [lats_pkg::NR_W-1:0]   nr;
    logic [lats_pkg::NC_W-1:0]   nc;

    // captured request
    logic [1:0] func_reg, func_next;
    logic [5:0] row_reg, row_next;
    logic [5:0] col_reg, col_next;
    logic       val_reg, val_next;

    // generation sequencing
    logic [lats_pkg::ROW_W-1:0] r_reg, r_next;
    logic [lats_pkg::COL_W-1:0] c_reg, c_next;
    logic                       last_row, last_col;

    // line buffers; up, cur, dn, prev and saved0 hold old-generation rows, new_row the row being built
    logic [MC-1:0] up_reg, up_next;
    logic [MC-1:0] cur_reg, cur_next;
    logic [MC-1:0] dn_reg, dn_next;
    logic [MC-1:0] prev_reg, prev_next;     // old row r-1, already overwritten in store
    logic [MC-1:0] saved0_reg, saved0_next; // old row 0, for the wrap at the last row
    logic [MC-1:0] new_row_reg, new_row_next;

    // result
    logic res_cv_reg, res_cv_next;
    logic res_acc_reg, res_acc_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [1:0] m_data_reg, m_data_next;

    // store
    lats_pkg::mem_req_t mem_req;
    logic [MC-1:0]      mem_wdata;
    logic [MC-1:0]      mem_rdata;
    logic               cell_bit;

    logic [1:0] in_func;
    logic [5:0] in_row, in_col;
    logic       in_range;

    lats_row_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .wr_data (mem_wdata),
        .rd_data (mem_rdata)
    );

    lats_cell_unit u_cell
    (
        .up_row    (up_reg),
        .cur_row   (cur_reg),
        .dn_row    (dn_reg),
        .col       (c_reg),
        .nc        (nc),
        .cell_next (cell_bit)
    );

    assign nr = lats_pkg::clamp_rows(rows_cfg_reg);
    assign nc = lats_pkg::clamp_cols(cols_cfg_reg);

    assign in_func  = s_tuser;
    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_range = (32'(in_row) < 32'(nr)) && (32'(in_col) < 32'(nc));

    assign last_row = (lats_pkg::NR_W'(r_reg) + 1'b1) == nr;
    assign last_col = (lats_pkg::NC_W'(c_reg) + 1'b1) == nc;

    assign s_tready = (state_reg == lats_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_data_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= lats_pkg::ROWS_RESET;
            cols_cfg_reg <= lats_pkg::COLS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lats_pkg::CFG_ROWS: rows_cfg_reg <= cfg_data;
                lats_pkg::CFG_COLS: cols_cfg_reg <= cfg_data;
                default:            rows_cfg_reg <= rows_cfg_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lats_pkg::ST_IDLE;
            r_reg        <= '0;
            c_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        val_reg     <= val_next;
        up_reg      <= up_next;
        cur_reg     <= cur_next;
        dn_reg      <= dn_next;
        prev_reg    <= prev_next;
        saved0_reg  <= saved0_next;
        new_row_reg <= new_row_next;
        res_cv_reg  <= res_cv_next;
        res_acc_reg <= res_acc_next;
        m_data_reg  <= m_data_next;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        val_next      = val_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        up_next       = up_reg;
        cur_next      = cur_reg;
        dn_next       = dn_reg;
        prev_next     = prev_reg;
        saved0_next   = saved0_reg;
        new_row_next  = new_row_reg;
        res_cv_next   = res_cv_reg;
        res_acc_next  = res_acc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        mem_req       = '0;
        mem_wdata     = new_row_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            lats_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next    = in_func;
                    row_next     = in_row;
                    col_next     = in_col;
                    val_next     = s_tdata[12];
                    res_cv_next  = 1'b0;
                    res_acc_next = 1'b0;
                    case (in_func)
                        lats_pkg::FUNC_STEP:
                        begin
                            r_next     = '0;
                            state_next = lats_pkg::ST_ROW_START;
                        end
                        lats_pkg::FUNC_WRITE, lats_pkg::FUNC_READ:
                            state_next = in_range ? lats_pkg::ST_ACC_RD : lats_pkg::ST_RESULT;
                        default:
                            state_next = lats_pkg::ST_RESULT;
                    endcase
                end
            end

            lats_pkg::ST_ACC_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = lats_pkg::ROW_W'(row_reg);
                state_next      = lats_pkg::ST_ACC_USE;
            end

            lats_pkg::ST_ACC_USE:
            begin
                // single-cell write is a read-modify-write of the whole row
                mem_wdata = mem_rdata;
                mem_wdata[lats_pkg::COL_W'(col_reg)] = val_reg;
                if (func_reg == lats_pkg::FUNC_WRITE)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = lats_pkg::ROW_W'(row_reg);
                    res_cv_next     = 1'b0;
                end
                else
                begin
                    res_cv_next = mem_rdata[lats_pkg::COL_W'(col_reg)];
                end
                res_acc_next = 1'b1;
                state_next   = lats_pkg::ST_RESULT;
            end

            lats_pkg::ST_ROW_START:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_reg;
                state_next      = lats_pkg::ST_GEN_RD_DN;
            end

            lats_pkg::ST_GEN_RD_DN:
            begin
                cur_next = mem_rdata;
                if (r_reg == '0)
                    saved0_next = mem_rdata;
                if (!last_row)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_reg + 1'b1;
                end
                state_next = lats_pkg::ST_GEN_RD_UP;
            end

            lats_pkg::ST_GEN_RD_UP:
            begin
                // row below wraps to old row 0 on the last row
                dn_next = last_row ? saved0_reg : mem_rdata;
                if (r_reg == '0)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = lats_pkg::ROW_W'(nr - 1'b1);
                end
                state_next = lats_pkg::ST_GEN_UP;
            end

            lats_pkg::ST_GEN_UP:
            begin
                up_next      = (r_reg == '0) ? mem_rdata : prev_reg;
                new_row_next = cur_reg;   // columns outside the grid keep their value
                c_next       = '0;
                state_next   = lats_pkg::ST_GEN_CELLS;
            end

            lats_pkg::ST_GEN_CELLS:
            begin
                new_row_next[c_reg] = cell_bit;
                if (last_col)
                    state_next = lats_pkg::ST_GEN_WB;
                else
                    c_next = c_reg + 1'b1;
            end

            lats_pkg::ST_GEN_WB:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_reg;
                prev_next       = cur_reg;
                if (last_row)
                begin
                    res_cv_next  = 1'b0;
                    res_acc_next = 1'b1;
                    state_next   = lats_pkg::ST_RESULT;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = lats_pkg::ST_ROW_START;
                end
            end

            lats_pkg::ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {res_acc_reg, res_cv_reg};
                    state_next    = lats_pkg::ST_IDLE;
                end
            end

            default:
                state_next = lats_pkg::ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lats_pkg::ST_GEN_CELLS) |-> (lats_pkg::NC_W'(c_reg) < nc))
        else $error("column counter beyond grid in use");

    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lats_pkg::ST_GEN_WB) |-> (lats_pkg::NR_W'(r_reg) < nr))
        else $error("row write-back beyond grid in use");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == lats_pkg::ST_RESULT))
        else $error("result raised outside result state");

    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg == lats_pkg::ST_ACC_USE
                           || state_reg == lats_pkg::ST_GEN_WB))
        else $error("cell store written outside a write or row write-back");
`endif

endmodule
